@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/trr_pkg.sv @@
package trr_pkg;

    localparam int DIM_MAX = 256;

    localparam int SIZE_W  = 9;
    localparam int COORD_W = 7;
    localparam int ROW_W   = 21;
    localparam int COL_W   = 24;
    localparam int WGT_W   = 4;
    localparam int CNT_W   = 26;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [2:0] REG_FINE_SIZE_X = 3'd0;
    localparam logic [2:0] REG_FINE_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_FINE_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_OPEN_X      = 3'd3;
    localparam logic [2:0] REG_OPEN_Y      = 3'd4;
    localparam logic [2:0] REG_OPEN_Z      = 3'd5;

    localparam logic [1:0] OFS_LOW  = 2'd0;
    localparam logic [1:0] OFS_MID  = 2'd1;
    localparam logic [1:0] OFS_HIGH = 2'd2;

    localparam logic [WGT_W-1:0] WGT_CENTER = 4'd8;

    typedef struct packed {
        logic [COORD_W-1:0] coarse_x;
        logic [COORD_W-1:0] coarse_y;
        logic [COORD_W-1:0] coarse_z;
    } t_in;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] column_index;
        logic [WGT_W-1:0] weight_64ths;
        logic [CNT_W-1:0] entry_index;
        logic             last;
        logic             range_error;
    } t_out;

    typedef struct packed {
        logic [SIZE_W-1:0] fine_size_x;
        logic [SIZE_W-1:0] fine_size_y;
        logic [SIZE_W-1:0] fine_size_z;
        logic              open_x;
        logic              open_y;
        logic              open_z;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] n);
        return (n > SIZE_W'(DIM_MAX)) ? SIZE_W'(DIM_MAX) : n;
    endfunction

    function automatic logic [WGT_W-1:0] weight_of(input logic [1:0] ix,
                                                   input logic [1:0] iy,
                                                   input logic [1:0] iz);
        logic [1:0] hops;
        hops = 2'(ix != OFS_MID) + 2'(iy != OFS_MID) + 2'(iz != OFS_MID);
        return WGT_CENTER >> hops;
    endfunction

endpackage

@@ src/trr_cfg.sv @@
module trr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trr_pkg::ADDR_W-1:0]    paddr,
    input  logic [trr_pkg::DATA_W-1:0]    pwdata,
    output logic [trr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output trr_pkg::t_cfg                 o_cfg
);

    trr_pkg::t_cfg r_cfg;
    trr_pkg::t_cfg n_cfg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (idx)
                trr_pkg::REG_FINE_SIZE_X: n_cfg.fine_size_x = pwdata[trr_pkg::SIZE_W-1:0];
                trr_pkg::REG_FINE_SIZE_Y: n_cfg.fine_size_y = pwdata[trr_pkg::SIZE_W-1:0];
                trr_pkg::REG_FINE_SIZE_Z: n_cfg.fine_size_z = pwdata[trr_pkg::SIZE_W-1:0];
                trr_pkg::REG_OPEN_X:      n_cfg.open_x      = pwdata[0];
                trr_pkg::REG_OPEN_Y:      n_cfg.open_y      = pwdata[0];
                trr_pkg::REG_OPEN_Z:      n_cfg.open_z      = pwdata[0];
                default:                  n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fine_size_x <= trr_pkg::SIZE_W'(trr_pkg::DIM_MAX);
            r_cfg.fine_size_y <= trr_pkg::SIZE_W'(trr_pkg::DIM_MAX);
            r_cfg.fine_size_z <= trr_pkg::SIZE_W'(trr_pkg::DIM_MAX);
            r_cfg.open_x      <= 1'b0;
            r_cfg.open_y      <= 1'b0;
            r_cfg.open_z      <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (idx)
            trr_pkg::REG_FINE_SIZE_X: prdata = trr_pkg::DATA_W'(r_cfg.fine_size_x);
            trr_pkg::REG_FINE_SIZE_Y: prdata = trr_pkg::DATA_W'(r_cfg.fine_size_y);
            trr_pkg::REG_FINE_SIZE_Z: prdata = trr_pkg::DATA_W'(r_cfg.fine_size_z);
            trr_pkg::REG_OPEN_X:      prdata = trr_pkg::DATA_W'(r_cfg.open_x);
            trr_pkg::REG_OPEN_Y:      prdata = trr_pkg::DATA_W'(r_cfg.open_y);
            trr_pkg::REG_OPEN_Z:      prdata = trr_pkg::DATA_W'(r_cfg.open_z);
            default:                  prdata = '0;
        endcase
    end

endmodule

@@ src/trr_ctrl.sv @@
module trr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output trr_pkg::t_cmd o_cmd,
    input  trr_pkg::t_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_MUL2 = 5'b00100,
        S_SUM  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   emit;

    assign emit        = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.mul1 = (r_state == S_MUL1);
    assign o_cmd.mul2 = (r_state == S_MUL2);
    assign o_cmd.sum  = (r_state == S_SUM);
    assign o_cmd.emit = emit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_EMIT;
            S_EMIT: begin
                if (emit && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = emit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/trr_dp.sv @@
module trr_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  trr_pkg::t_cmd i_cmd,
    input  trr_pkg::t_cfg i_cfg,
    input  trr_pkg::t_in  i_in_data,
    output trr_pkg::t_out o_out_data,
    output trr_pkg::t_sts o_sts
);

    // captured item and effective sizes
    logic [6:0]  r_cx, r_cy, r_cz;
    logic [8:0]  r_nx, r_ny, r_nz;

    // first product step
    logic        r_err;
    logic [14:0] r_mxmy;
    logic [16:0] r_nxny;
    logic [14:0] r_cymx;
    logic [15:0] r_y0;
    logic        r_wx, r_wy, r_wz;
    logic [1:0]  r_lx, r_ly, r_lz;

    // second product step
    logic [20:0] r_czmxmy;
    logic [23:0] r_z0;

    // scan state
    logic [20:0] r_row;
    logic [1:0]  r_ix, r_iy, r_iz;
    logic [7:0]  r_x;
    logic [15:0] r_yoff;
    logic [23:0] r_zoff;

    logic [25:0]   r_cnt;
    trr_pkg::t_out r_out;

    logic [15:0] mxmy_full;
    logic [17:0] nxny_full;
    logic [14:0] cymx_full;
    logic [16:0] y0_full;
    logic [21:0] czmxmy_full;
    logic [24:0] z0_full;
    logic [8:0]  fx2, fy2, fz2;
    logic        err;
    logic        x_last, y_last, z_last, iter_last;
    logic [1:0]  ix_inc, iy_inc, iz_inc;
    logic [16:0] yoff_inc;
    logic [24:0] zoff_inc;
    logic [23:0] col;

    assign mxmy_full   = 16'(r_nx[8:1]) * 16'(r_ny[8:1]);
    assign nxny_full   = 18'(r_nx) * 18'(r_ny);
    assign cymx_full   = 15'(r_cy) * 15'(r_nx[8:1]);
    assign y0_full     = 17'({r_cy, 1'b0}) * 17'(r_nx);
    assign czmxmy_full = 22'(r_cz) * 22'(r_mxmy);
    assign z0_full     = 25'({r_cz, 1'b0}) * 25'(r_nxny);

    assign fx2 = 9'({r_cx, 1'b0}) + 9'd2;
    assign fy2 = 9'({r_cy, 1'b0}) + 9'd2;
    assign fz2 = 9'({r_cz, 1'b0}) + 9'd2;

    assign err = ({1'b0, r_cx} >= r_nx[8:1]) ||
                 ({1'b0, r_cy} >= r_ny[8:1]) ||
                 ({1'b0, r_cz} >= r_nz[8:1]);

    assign x_last    = (r_ix == r_lx);
    assign y_last    = (r_iy == r_ly);
    assign z_last    = (r_iz == r_lz);
    assign iter_last = x_last && y_last && z_last;
    assign ix_inc    = r_ix + 2'd1;
    assign iy_inc    = r_iy + 2'd1;
    assign iz_inc    = r_iz + 2'd1;
    assign yoff_inc  = {1'b0, r_yoff} + {8'd0, r_nx};
    assign zoff_inc  = {1'b0, r_zoff} + {8'd0, r_nxny};
    assign col       = {16'd0, r_x} + {8'd0, r_yoff} + r_zoff;

    assign o_sts.last = r_err || iter_last;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= i_in_data.coarse_x;
            r_cy <= i_in_data.coarse_y;
            r_cz <= i_in_data.coarse_z;
            r_nx <= trr_pkg::eff_size(i_cfg.fine_size_x);
            r_ny <= trr_pkg::eff_size(i_cfg.fine_size_y);
            r_nz <= trr_pkg::eff_size(i_cfg.fine_size_z);
        end
        if (i_cmd.mul1) begin
            r_err  <= err;
            r_mxmy <= mxmy_full[14:0];
            r_nxny <= nxny_full[16:0];
            r_cymx <= cymx_full;
            r_y0   <= y0_full[15:0];
            r_wx   <= (fx2 == r_nx);
            r_wy   <= (fy2 == r_ny);
            r_wz   <= (fz2 == r_nz);
            r_lx   <= (!i_cfg.open_x || fx2 != r_nx) ? trr_pkg::OFS_HIGH : trr_pkg::OFS_MID;
            r_ly   <= (!i_cfg.open_y || fy2 != r_ny) ? trr_pkg::OFS_HIGH : trr_pkg::OFS_MID;
            r_lz   <= (!i_cfg.open_z || fz2 != r_nz) ? trr_pkg::OFS_HIGH : trr_pkg::OFS_MID;
        end
        if (i_cmd.mul2) begin
            r_czmxmy <= czmxmy_full[20:0];
            r_z0     <= z0_full[23:0];
        end
        if (i_cmd.sum) begin
            r_row  <= 21'(r_cx) + 21'(r_cymx) + r_czmxmy;
            r_ix   <= trr_pkg::OFS_LOW;
            r_iy   <= trr_pkg::OFS_LOW;
            r_iz   <= trr_pkg::OFS_LOW;
            r_x    <= {r_cx, 1'b0};
            r_yoff <= r_y0;
            r_zoff <= r_z0;
        end else if (i_cmd.emit) begin
            if (!x_last) begin
                r_ix <= ix_inc;
                r_x  <= (ix_inc == trr_pkg::OFS_HIGH && r_wx) ? 8'd0 : r_x + 8'd1;
            end else begin
                r_ix <= trr_pkg::OFS_LOW;
                r_x  <= {r_cx, 1'b0};
                if (!y_last) begin
                    r_iy   <= iy_inc;
                    r_yoff <= (iy_inc == trr_pkg::OFS_HIGH && r_wy) ? 16'd0 : yoff_inc[15:0];
                end else begin
                    r_iy   <= trr_pkg::OFS_LOW;
                    r_yoff <= r_y0;
                    if (!z_last) begin
                        r_iz   <= iz_inc;
                        r_zoff <= (iz_inc == trr_pkg::OFS_HIGH && r_wz) ? 24'd0 : zoff_inc[23:0];
                    end
                end
            end
        end
        if (i_cmd.emit) begin
            if (r_err) begin
                r_out.row_index    <= '0;
                r_out.column_index <= '0;
                r_out.weight_64ths <= '0;
                r_out.entry_index  <= '0;
                r_out.last         <= 1'b1;
                r_out.range_error  <= 1'b1;
            end else begin
                r_out.row_index    <= r_row;
                r_out.column_index <= col;
                r_out.weight_64ths <= trr_pkg::weight_of(r_ix, r_iy, r_iz);
                r_out.entry_index  <= r_cnt;
                r_out.last         <= iter_last;
                r_out.range_error  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.emit && !r_err) begin
            r_cnt <= r_cnt + 26'd1;
        end
    end

endmodule

@@ src/trilinear_restriction_rows.sv @@
// Trilinear restriction row generator. Each coarse point transfer yields the nonzero
// entries of its restriction row, one result transfer per cycle while the output is
// not stalled, after the setup steps: an item yields 8 to 27 entries (three neighbours per
// periodic axis, two per open axis whose high neighbour falls off the grid), or a
// single error entry for an out-of-range point. The setup steps are the capture, the
// two product steps that form the row and plane offsets, and the sum step that forms
// the row index; entries then leave through a single output register, and the next
// point is taken once the last entry of the row is in that register.
module trilinear_restriction_rows (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  trr_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output trr_pkg::t_out                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trr_pkg::ADDR_W-1:0]    paddr,
    input  logic [trr_pkg::DATA_W-1:0]    pwdata,
    output logic [trr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    trr_pkg::t_cfg cfg;
    trr_pkg::t_cmd cmd;
    trr_pkg::t_sts sts;

    trr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    trr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    trr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .o_sts      (sts)
    );

endmodule

@@ src/trr_checker.sv @@
`include "assert_macros.svh"

module trr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input trr_pkg::t_out o_out_data
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "accepted a second point without setup")
    `ASSERT_CLK(a_err_is_last, i_clk, i_rst_n, o_out_valid && o_out_data.range_error |-> o_out_data.last && o_out_data.weight_64ths == '0, "error result not a lone zero entry")
    `ASSERT_NEVER(a_zero_weight, i_clk, i_rst_n, o_out_valid && !o_out_data.range_error && o_out_data.weight_64ths == '0, "entry with zero weight")

endmodule

bind trilinear_restriction_rows trr_checker u_trr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
